// ===== design/rmr_pkg.sv =====
// -----------------------------------------------------------------------------
// rmr_pkg
// Shared types and fixed-point constants for the rotation matrix renormaliser.
// -----------------------------------------------------------------------------
package rmr_pkg;

   // Matrix geometry.
   localparam int N         = 3;
   localparam int N_ENTRIES = N * N;

   // Entry format: signed Q2.14.
   localparam int ENTRY_W = 16;

   // Squares of entries and their column sums.
   localparam int SQ_W  = 32;
   localparam int NSQ_W = 34;

   // Scale factor 1.5 - norm_sq/2 in Q.29; it spans [-9*2^28, 3*2^28].
   localparam int F_W = 33;

   // Entry times scale factor (Q.43) and the rounded scaled entry (Q.14).
   localparam int SP_W  = ENTRY_W + F_W;
   localparam int S_W   = 19;
   localparam int SHIFT = 29;

   // Products of scaled entries, their sums (half dot products in Q.29).
   localparam int PP_W  = 2 * S_W;
   localparam int SUM_W = PP_W + 2;
   localparam int D_W   = 37;

   // Correction products and the full Q.43 output sum.
   localparam int CP_W = D_W + S_W;
   localparam int T_W  = CP_W + 2;
   localparam int Q_W  = T_W - SHIFT;

   // Largest magnitude a scaled entry can take.
   localparam int S_LIMIT = 147456;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef entry_type                 mat_type [N_ENTRIES];
   typedef logic signed [S_W-1:0]     scaled_type;
   typedef scaled_type                smat_type [N_ENTRIES];
   typedef logic signed [D_W-1:0]     dot_type;

   // Half dot products of columns 0-1, 0-2 and 1-2.
   typedef struct packed {
      dot_type a;
      dot_type b;
      dot_type g;
   } half_dot_type;

   // 1.5 in Q.29, held at the width of the norm sum.
   localparam logic signed [NSQ_W-1:0] F_THREE_HALVES = NSQ_W'(64'sd805306368);

   // One half in Q.29, added before a floor shift to round half up.
   localparam logic signed [SP_W-1:0] ROUND_SP = SP_W'(64'sd268435456);
   localparam logic signed [T_W-1:0]  ROUND_T  = T_W'(64'sd268435456);

   localparam entry_type ENTRY_MAX = 16'sh7fff;
   localparam entry_type ENTRY_MIN = 16'sh8000;

endpackage

// ===== design/rmr_scale.sv =====
// -----------------------------------------------------------------------------
// rmr_scale
// Stages one to three: column norms, scale factors and scaled entries.
// -----------------------------------------------------------------------------
module rmr_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  rmr_pkg::mat_type  in_mat,
   output logic              out_vld,
   output rmr_pkg::smat_type out_s
);
   import rmr_pkg::*;

   logic                          vld1_ff, vld2_ff, vld3_ff;
   logic signed [SQ_W-1:0]        sq_in [N_ENTRIES];
   logic signed [SQ_W-1:0]        sq_ff [N_ENTRIES];
   mat_type                       m1_ff, m2_ff;
   logic signed [F_W-1:0]         f_in [N];
   logic signed [F_W-1:0]         f_ff [N];
   smat_type                      s_in, s_ff;
   logic                          s_in_range;

   // Valid bits follow the data through the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   // Stage one: square every entry.
   always_comb begin
      for (int k = 0; k < N_ENTRIES; k++) begin
         sq_in[k] = SQ_W'(in_mat[k]) * SQ_W'(in_mat[k]);
      end
   end

   // Stage two: column sums of squares give the scale factor 1.5 - norm_sq/2.
   always_comb begin
      logic signed [NSQ_W-1:0] nsq;
      logic signed [NSQ_W-1:0] f_wide;
      for (int j = 0; j < N; j++) begin
         nsq = NSQ_W'(sq_ff[j]) + NSQ_W'(sq_ff[N + j]) + NSQ_W'(sq_ff[2 * N + j]);
         f_wide = F_THREE_HALVES - nsq;
         f_in[j] = F_W'(f_wide);
      end
   end

   // Stage three: scale each entry and round from Q.43 to Q.14, half up.
   always_comb begin
      logic signed [SP_W-1:0] p;
      for (int k = 0; k < N_ENTRIES; k++) begin
         p = SP_W'(m2_ff[k]) * SP_W'(f_ff[k % N]) + ROUND_SP;
         s_in[k] = $signed(p[SHIFT+S_W-1:SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      m1_ff <= in_mat;
      m2_ff <= m1_ff;
      f_ff  <= f_in;
      s_ff  <= s_in;
   end

   assign out_vld = vld3_ff;
   assign out_s   = s_ff;

   // Range check on the scaled entries.
   always_comb begin
      s_in_range = 1'b1;
      for (int k = 0; k < N_ENTRIES; k++) begin
         if (s_ff[k] > S_W'(S_LIMIT) || s_ff[k] < -S_W'(S_LIMIT)) begin
            s_in_range = 1'b0;
         end
      end
   end

   // The scale factor can never exceed one and a half.
   a_f_bound: assert property (@(posedge clock) disable iff (reset)
      vld2_ff |-> (f_ff[0] <= F_W'(F_THREE_HALVES) && f_ff[1] <= F_W'(F_THREE_HALVES)
                   && f_ff[2] <= F_W'(F_THREE_HALVES)))
      else $error("scale factor above one and a half");

   // Scaled entries stay within their worst-case magnitude.
   a_s_range: assert property (@(posedge clock) disable iff (reset)
      vld3_ff |-> s_in_range)
      else $error("scaled entry out of range");

endmodule

// ===== design/rmr_dot.sv =====
// -----------------------------------------------------------------------------
// rmr_dot
// Stages four and five: half dot products of the scaled columns.
// -----------------------------------------------------------------------------
module rmr_dot (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  rmr_pkg::smat_type      in_s,
   output logic                   out_vld,
   output rmr_pkg::smat_type      out_s,
   output rmr_pkg::half_dot_type  out_dot
);
   import rmr_pkg::*;

   logic                    vld4_ff, vld5_ff;
   logic signed [PP_W-1:0]  pa_in [N];
   logic signed [PP_W-1:0]  pb_in [N];
   logic signed [PP_W-1:0]  pg_in [N];
   logic signed [PP_W-1:0]  pa_ff [N];
   logic signed [PP_W-1:0]  pb_ff [N];
   logic signed [PP_W-1:0]  pg_ff [N];
   smat_type                s4_ff, s5_ff;
   half_dot_type            dot_in, dot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         vld4_ff <= in_vld;
         vld5_ff <= vld4_ff;
      end
   end

   // Stage four: per-row products of column pairs.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         pa_in[i] = PP_W'(in_s[i*N])     * PP_W'(in_s[i*N + 1]);
         pb_in[i] = PP_W'(in_s[i*N])     * PP_W'(in_s[i*N + 2]);
         pg_in[i] = PP_W'(in_s[i*N + 1]) * PP_W'(in_s[i*N + 2]);
      end
   end

   // Stage five: sum the rows; the Q.28 dot product read as Q.29 is its half.
   always_comb begin
      dot_in.a = D_W'(SUM_W'(pa_ff[0]) + SUM_W'(pa_ff[1]) + SUM_W'(pa_ff[2]));
      dot_in.b = D_W'(SUM_W'(pb_ff[0]) + SUM_W'(pb_ff[1]) + SUM_W'(pb_ff[2]));
      dot_in.g = D_W'(SUM_W'(pg_ff[0]) + SUM_W'(pg_ff[1]) + SUM_W'(pg_ff[2]));
   end

   always_ff @(posedge clock) begin
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      pg_ff  <= pg_in;
      s4_ff  <= in_s;
      s5_ff  <= s4_ff;
      dot_ff <= dot_in;
   end

   assign out_vld = vld5_ff;
   assign out_s   = s5_ff;
   assign out_dot = dot_ff;

endmodule

// ===== design/rmr_correct.sv =====
// -----------------------------------------------------------------------------
// rmr_correct
// Stages six to eight: cross-coupling correction, rounding and saturation.
// -----------------------------------------------------------------------------
module rmr_correct (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  rmr_pkg::smat_type      in_s,
   input  rmr_pkg::half_dot_type  in_dot,
   output logic                   out_vld,
   output rmr_pkg::mat_type       out_mat
);
   import rmr_pkg::*;

   logic                    vld6_ff, vld7_ff, vld8_ff;
   logic signed [CP_W-1:0]  c0_in [N_ENTRIES];
   logic signed [CP_W-1:0]  c1_in [N_ENTRIES];
   logic signed [CP_W-1:0]  c0_ff [N_ENTRIES];
   logic signed [CP_W-1:0]  c1_ff [N_ENTRIES];
   smat_type                s6_ff;
   logic signed [T_W-1:0]   t_in [N_ENTRIES];
   logic signed [T_W-1:0]   t_ff [N_ENTRIES];
   mat_type                 out_in, out_ff;

   // Clamp a rounded Q.14 value to the signed 16-bit range.
   function automatic entry_type sat_entry(input logic signed [Q_W-1:0] q);
      entry_type r;
      if (q > Q_W'(ENTRY_MAX)) begin
         r = ENTRY_MAX;
      end else if (q < Q_W'(ENTRY_MIN)) begin
         r = ENTRY_MIN;
      end else begin
         r = $signed(q[ENTRY_W-1:0]);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else begin
         vld6_ff <= in_vld;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
      end
   end

   // Stage six: each entry is corrected by the other two entries of its row.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         c0_in[i*N]     = CP_W'(in_dot.a) * CP_W'(in_s[i*N + 1]);
         c1_in[i*N]     = CP_W'(in_dot.b) * CP_W'(in_s[i*N + 2]);
         c0_in[i*N + 1] = CP_W'(in_dot.a) * CP_W'(in_s[i*N]);
         c1_in[i*N + 1] = CP_W'(in_dot.g) * CP_W'(in_s[i*N + 2]);
         c0_in[i*N + 2] = CP_W'(in_dot.b) * CP_W'(in_s[i*N]);
         c1_in[i*N + 2] = CP_W'(in_dot.g) * CP_W'(in_s[i*N + 1]);
      end
   end

   // Stage seven: form the exact Q.43 sum with the rounding half folded in.
   always_comb begin
      for (int k = 0; k < N_ENTRIES; k++) begin
         t_in[k] = (T_W'(s6_ff[k]) <<< SHIFT) - T_W'(c0_ff[k]) - T_W'(c1_ff[k]) + ROUND_T;
      end
   end

   // Stage eight: floor shift to Q.14 and saturate.
   always_comb begin
      for (int k = 0; k < N_ENTRIES; k++) begin
         out_in[k] = sat_entry($signed(t_ff[k][T_W-1:SHIFT]));
      end
   end

   always_ff @(posedge clock) begin
      c0_ff  <= c0_in;
      c1_ff  <= c1_in;
      s6_ff  <= in_s;
      t_ff   <= t_in;
      out_ff <= out_in;
   end

   assign out_vld = vld8_ff;
   assign out_mat = out_ff;

endmodule

// ===== design/rotation_matrix_renormalize.sv =====
// -----------------------------------------------------------------------------
// rotation_matrix_renormalize
// First-order re-orthonormalisation of a 3x3 signed Q2.14 matrix.
// -----------------------------------------------------------------------------
// A request taken at a clock edge gives its result on the rsp_ ports once
// it has passed the pipeline, for one cycle only. Throughput: one request
// per cycle while busy is low; the eight-stage pipeline never stalls.
// Reset clears every valid bit, so requests in flight are dropped, and busy
// is high during reset and in the cycle after it.
// -----------------------------------------------------------------------------
module rotation_matrix_renormalize (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rmr_pkg::entry_type  req_in_00,
   input  rmr_pkg::entry_type  req_in_01,
   input  rmr_pkg::entry_type  req_in_02,
   input  rmr_pkg::entry_type  req_in_10,
   input  rmr_pkg::entry_type  req_in_11,
   input  rmr_pkg::entry_type  req_in_12,
   input  rmr_pkg::entry_type  req_in_20,
   input  rmr_pkg::entry_type  req_in_21,
   input  rmr_pkg::entry_type  req_in_22,
   output logic                rsp_strobe,
   output rmr_pkg::entry_type  rsp_out_00,
   output rmr_pkg::entry_type  rsp_out_01,
   output rmr_pkg::entry_type  rsp_out_02,
   output rmr_pkg::entry_type  rsp_out_10,
   output rmr_pkg::entry_type  rsp_out_11,
   output rmr_pkg::entry_type  rsp_out_12,
   output rmr_pkg::entry_type  rsp_out_20,
   output rmr_pkg::entry_type  rsp_out_21,
   output rmr_pkg::entry_type  rsp_out_22
);
   import rmr_pkg::*;

   logic          busy_ff;
   logic          req_take;
   mat_type       req_mat;
   logic          scale_vld, dot_vld, corr_vld;
   smat_type      scale_s, dot_s;
   half_dot_type  dot_val;
   mat_type       corr_mat;

   // The pipeline takes a request every cycle once busy has gone low after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign req_take = start && !busy_ff;

   // Gather the request entries in row-major order.
   assign req_mat[0] = req_in_00;
   assign req_mat[1] = req_in_01;
   assign req_mat[2] = req_in_02;
   assign req_mat[3] = req_in_10;
   assign req_mat[4] = req_in_11;
   assign req_mat[5] = req_in_12;
   assign req_mat[6] = req_in_20;
   assign req_mat[7] = req_in_21;
   assign req_mat[8] = req_in_22;

   rmr_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (req_take),
      .in_mat  (req_mat),
      .out_vld (scale_vld),
      .out_s   (scale_s)
   );

   rmr_dot u_dot (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (scale_vld),
      .in_s    (scale_s),
      .out_vld (dot_vld),
      .out_s   (dot_s),
      .out_dot (dot_val)
   );

   rmr_correct u_correct (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (dot_vld),
      .in_s    (dot_s),
      .in_dot  (dot_val),
      .out_vld (corr_vld),
      .out_mat (corr_mat)
   );

   // Result ports.
   assign rsp_strobe = corr_vld;
   assign rsp_out_00 = corr_mat[0];
   assign rsp_out_01 = corr_mat[1];
   assign rsp_out_02 = corr_mat[2];
   assign rsp_out_10 = corr_mat[3];
   assign rsp_out_11 = corr_mat[4];
   assign rsp_out_12 = corr_mat[5];
   assign rsp_out_20 = corr_mat[6];
   assign rsp_out_21 = corr_mat[7];
   assign rsp_out_22 = corr_mat[8];

   // Every request taken yields a result on rsp_strobe.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##8 rsp_strobe)
      else $error("request produced no result");

   // No result appears without a matching earlier request.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_take, 8))
      else $error("result without a request");

endmodule

// ===== test/rotation_matrix_renormalize_tb.sv =====
// -----------------------------------------------------------------------------
// rotation_matrix_renormalize_tb
// Self-checking testbench for the rotation matrix renormaliser. A short table
// of directed matrices (zero, identity, extremes, saturating and skewed cases)
// is followed by random matrices: perturbed rotations and raw bit patterns.
// Most accepted requests are run through a fixed-point predictor in the
// testbench, and each strobed result is compared entry by entry with the
// oldest prediction. The sender idles at random, at three levels in turn.
// -----------------------------------------------------------------------------
module rotation_matrix_renormalize_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rmr_pkg::*;

   localparam int NUM_RANDOM    = 1600;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int NUM_DIRECTED  = 18;

   // Q.29 fixed-point constants of the correction arithmetic.
   localparam longint ONE_Q29          = 64'sd536870912;
   localparam longint HALF_Q29         = 64'sd268435456;
   localparam longint THREE_HALVES_Q29 = 64'sd805306368;

   // Nine entries, M[0][0] first, as one packed word.
   typedef logic [0:N_ENTRIES-1][ENTRY_W-1:0] flat_mat_type;

   // One row of the directed table; want is used only where known is set.
   typedef struct packed {
      logic         known;
      flat_mat_type stim;
      flat_mat_type want;
   } directed_row_type;

   localparam entry_type Z_Q14       = 16'sh0000;
   localparam entry_type ONE_Q14     = 16'sh4000;
   localparam entry_type NEG_ONE_Q14 = 16'shc000;
   localparam entry_type COS45_Q14   = 16'sd11585;
   localparam entry_type NCOS45_Q14  = -16'sd11585;
   localparam entry_type TENTH_Q14   = 16'sd1638;
   localparam entry_type GROWN_Q14   = 16'sd18022;
   localparam entry_type SHRUNK_Q14  = 16'sd14746;

   localparam flat_mat_type ZERO_MAT  = '0;
   localparam flat_mat_type IDENT_MAT = {ONE_Q14, Z_Q14, Z_Q14, Z_Q14, ONE_Q14, Z_Q14,
                                         Z_Q14, Z_Q14, ONE_Q14};
   localparam flat_mat_type NEG_IDENT_MAT = {NEG_ONE_Q14, Z_Q14, Z_Q14, Z_Q14, NEG_ONE_Q14,
                                             Z_Q14, Z_Q14, Z_Q14, NEG_ONE_Q14};

   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      // Exactly orthonormal or zero: the result can be read off directly.
      '{1'b1, ZERO_MAT, ZERO_MAT},
      '{1'b1, IDENT_MAT, IDENT_MAT},
      '{1'b1, NEG_IDENT_MAT, NEG_IDENT_MAT},
      // Far from orthonormal, saturating both ways.
      '{1'b0, {9{ENTRY_MAX}}, ZERO_MAT},
      '{1'b0, {9{ENTRY_MIN}}, ZERO_MAT},
      '{1'b0, {ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN,
               ENTRY_MAX, ENTRY_MIN, ENTRY_MAX}, ZERO_MAT},
      '{1'b0, {ENTRY_MAX, {8{Z_Q14}}}, ZERO_MAT},
      '{1'b0, {{8{Z_Q14}}, ENTRY_MIN}, ZERO_MAT},
      '{1'b0, {{3{ENTRY_MAX}}, {3{ENTRY_MIN}}, {3{Z_Q14}}}, ZERO_MAT},
      // Permutation, uniform scaling and a rotation about one axis.
      '{1'b0, {Z_Q14, ONE_Q14, Z_Q14, Z_Q14, Z_Q14, ONE_Q14, ONE_Q14, Z_Q14, Z_Q14},
        ZERO_MAT},
      '{1'b0, {GROWN_Q14, Z_Q14, Z_Q14, Z_Q14, GROWN_Q14, Z_Q14, Z_Q14, Z_Q14, GROWN_Q14},
        ZERO_MAT},
      '{1'b0, {SHRUNK_Q14, Z_Q14, Z_Q14, Z_Q14, SHRUNK_Q14, Z_Q14, Z_Q14, Z_Q14,
               SHRUNK_Q14}, ZERO_MAT},
      '{1'b0, {COS45_Q14, NCOS45_Q14, Z_Q14, COS45_Q14, COS45_Q14, Z_Q14, Z_Q14, Z_Q14,
               ONE_Q14}, ZERO_MAT},
      // Groups that are not orthogonal to each other.
      '{1'b0, {ONE_Q14, TENTH_Q14, Z_Q14, Z_Q14, ONE_Q14, TENTH_Q14, TENTH_Q14, Z_Q14,
               ONE_Q14}, ZERO_MAT},
      // Alternating bit patterns and the smallest magnitudes, for rounding.
      '{1'b0, {9{16'sh5555}}, ZERO_MAT},
      '{1'b0, {9{16'shaaaa}}, ZERO_MAT},
      '{1'b0, {9{16'sh0001}}, ZERO_MAT},
      '{1'b0, {9{16'shffff}}, ZERO_MAT}
   };

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   entry_type req_in_00, req_in_01, req_in_02;
   entry_type req_in_10, req_in_11, req_in_12;
   entry_type req_in_20, req_in_21, req_in_22;
   logic      rsp_strobe;
   entry_type rsp_out_00, rsp_out_01, rsp_out_02;
   entry_type rsp_out_10, rsp_out_11, rsp_out_12;
   entry_type rsp_out_20, rsp_out_21, rsp_out_22;

   flat_mat_type pending_results [$];
   int           fault_count;

   rotation_matrix_renormalize i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_in_00  (req_in_00),
      .req_in_01  (req_in_01),
      .req_in_02  (req_in_02),
      .req_in_10  (req_in_10),
      .req_in_11  (req_in_11),
      .req_in_12  (req_in_12),
      .req_in_20  (req_in_20),
      .req_in_21  (req_in_21),
      .req_in_22  (req_in_22),
      .rsp_strobe (rsp_strobe),
      .rsp_out_00 (rsp_out_00),
      .rsp_out_01 (rsp_out_01),
      .rsp_out_02 (rsp_out_02),
      .rsp_out_10 (rsp_out_10),
      .rsp_out_11 (rsp_out_11),
      .rsp_out_12 (rsp_out_12),
      .rsp_out_20 (rsp_out_20),
      .rsp_out_21 (rsp_out_21),
      .rsp_out_22 (rsp_out_22)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Rounds a Q.43 value to Q.14, half up, and clips it to sixteen bits.
   function automatic entry_type round_saturate(input longint q43);
      longint q14;
      q14 = (q43 + HALF_Q29) >>> 29;
      if (q14 > longint'(ENTRY_MAX)) begin
         q14 = longint'(ENTRY_MAX);
      end
      if (q14 < longint'(ENTRY_MIN)) begin
         q14 = longint'(ENTRY_MIN);
      end
      return entry_type'(q14);
   endfunction

   // First-order renormalisation: rescale each group, then remove the
   // half dot products between groups.
   function automatic flat_mat_type renormalize(input flat_mat_type m);
      longint       e [N_ENTRIES];
      longint       sc [N_ENTRIES];
      longint       fac [3];
      longint       norm_sq, dot01, dot02, dot12;
      flat_mat_type r;
      for (int k = 0; k < N_ENTRIES; k++) begin
         e[k] = longint'($signed(m[k]));
      end
      for (int j = 0; j < 3; j++) begin
         norm_sq = e[j] * e[j] + e[3 + j] * e[3 + j] + e[6 + j] * e[6 + j];
         fac[j]  = THREE_HALVES_Q29 - norm_sq;
      end
      for (int k = 0; k < N_ENTRIES; k++) begin
         sc[k] = (e[k] * fac[k % 3] + HALF_Q29) >>> 29;
      end
      dot01 = 0;
      dot02 = 0;
      dot12 = 0;
      for (int i = 0; i < 3; i++) begin
         dot01 += sc[3 * i] * sc[3 * i + 1];
         dot02 += sc[3 * i] * sc[3 * i + 2];
         dot12 += sc[3 * i + 1] * sc[3 * i + 2];
      end
      for (int i = 0; i < 3; i++) begin
         r[3 * i]     = round_saturate(sc[3 * i] * ONE_Q29 - dot01 * sc[3 * i + 1]
                                       - dot02 * sc[3 * i + 2]);
         r[3 * i + 1] = round_saturate(sc[3 * i + 1] * ONE_Q29 - dot01 * sc[3 * i]
                                       - dot12 * sc[3 * i + 2]);
         r[3 * i + 2] = round_saturate(sc[3 * i + 2] * ONE_Q29 - dot02 * sc[3 * i]
                                       - dot12 * sc[3 * i + 1]);
      end
      return r;
   endfunction

   // Mostly rotations with noise of random size, otherwise raw bit patterns.
   function automatic flat_mat_type random_matrix();
      real          ax, ay, az, cx, sx, cy, sy, cz, sz;
      real          rot [N_ENTRIES];
      int           span;
      int           value;
      flat_mat_type m;
      if ($urandom_range(99) < 35) begin
         for (int k = 0; k < N_ENTRIES; k++) begin
            m[k] = 16'($urandom);
         end
      end else begin
         ax = $urandom_range(62831) / 10000.0;
         ay = $urandom_range(62831) / 10000.0;
         az = $urandom_range(62831) / 10000.0;
         cx = $cos(ax);
         sx = $sin(ax);
         cy = $cos(ay);
         sy = $sin(ay);
         cz = $cos(az);
         sz = $sin(az);
         rot[0] = cz * cy;
         rot[1] = cz * sy * sx - sz * cx;
         rot[2] = cz * sy * cx + sz * sx;
         rot[3] = sz * cy;
         rot[4] = sz * sy * sx + cz * cx;
         rot[5] = sz * sy * cx - cz * sx;
         rot[6] = -sy;
         rot[7] = cy * sx;
         rot[8] = cy * cx;
         span = 1 << $urandom_range(13);
         for (int k = 0; k < N_ENTRIES; k++) begin
            value = $rtoi(rot[k] * 16384.0) + int'($urandom_range(2 * span)) - span;
            m[k]  = 16'(value);
         end
      end
      return m;
   endfunction

   // Prints one line for a failure and counts it.
   task automatic report_fault(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fault_count++;
   endtask

   // Offers one request, idling first at random, and waits until it is taken.
   task automatic send_request(input flat_mat_type m, input flat_mat_type want,
                               input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_in_00 <= m[0];
      req_in_01 <= m[1];
      req_in_02 <= m[2];
      req_in_10 <= m[3];
      req_in_11 <= m[4];
      req_in_12 <= m[5];
      req_in_20 <= m[6];
      req_in_21 <= m[7];
      req_in_22 <= m[8];
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_results.push_back(want);
   endtask

   // Holds the request side off until every outstanding result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus: reset, directed table, then three random phases.
   initial begin
      flat_mat_type m;
      fault_count = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_in_00 = '0;
      req_in_01 = '0;
      req_in_02 = '0;
      req_in_10 = '0;
      req_in_11 = '0;
      req_in_12 = '0;
      req_in_20 = '0;
      req_in_21 = '0;
      req_in_22 = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_DIRECTED; k++) begin
         send_request(DIRECTED[k].stim,
                      DIRECTED[k].known ? DIRECTED[k].want : renormalize(DIRECTED[k].stim),
                      13);
      end
      wait_for_results();

      // Sender idles now and then, then often, then never.
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < NUM_RANDOM / 3; n++) begin
            m = random_matrix();
            send_request(m, renormalize(m), (phase == 0) ? 13 : (phase == 1) ? 56 : 0);
         end
         wait_for_results();
      end

      // Let the pipeline run empty, so that a stray strobe is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Result check against the oldest prediction.
   always @(posedge clock) begin : result_check
      flat_mat_type got;
      flat_mat_type want;
      if (rsp_strobe === 1'b1) begin
         got = {rsp_out_00, rsp_out_01, rsp_out_02, rsp_out_10, rsp_out_11, rsp_out_12,
                rsp_out_20, rsp_out_21, rsp_out_22};
         if (pending_results.size() == 0) begin
            report_fault("result strobed with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            for (int k = 0; k < N_ENTRIES; k++) begin
               if (got[k] !== want[k]) begin
                  report_fault($sformatf("out_%0d%0d is %0d, expected %0d", k / 3, k % 3,
                                         $signed(got[k]), $signed(want[k])));
               end
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule

// ===== rotation_matrix_renormalize.f =====
design/rmr_pkg.sv
design/rmr_scale.sv
design/rmr_dot.sv
design/rmr_correct.sv
design/rotation_matrix_renormalize.sv
test/rotation_matrix_renormalize_tb.sv
